[src/cprr_pkg.sv]
// ----------------------------------------------------------------------------
// cprr_pkg: shared types and constants of the contour power ramp resampler
// Widths of the arithmetic datapath, result codes and register indexes.
// ----------------------------------------------------------------------------
package cprr_pkg;

    localparam int MAX_STEPS   = 63;
    localparam int STEP_W      = $clog2(MAX_STEPS + 1);
    localparam int MIN_GAP_UM  = 1;
    localparam int BUF_DEPTH   = MAX_STEPS + 1;
    localparam int BUF_AW      = $clog2(BUF_DEPTH);
    localparam int BUF_CW      = $clog2(BUF_DEPTH + 1);
    localparam int TRAV_W      = 22;
    localparam int NUM_W       = 54;
    localparam int DEN_W       = 33;
    localparam int ENTRY_W     = 130;

    localparam logic [63:0] MIN_GAP_SQ = 64'(MIN_GAP_UM * MIN_GAP_UM);

    typedef enum logic [2:0] {
        REG_RAMP_LENGTH  = 3'd0,
        REG_RAMP_STEP    = 3'd1,
        REG_CORE_START   = 3'd2,
        REG_CORE_END     = 3'd3,
        REG_RING_START   = 3'd4,
        REG_RING_END     = 3'd5,
        REG_START_INDEX  = 3'd6
    } reg_idx_t;

    localparam logic [1:0] KIND_RAMP   = 2'd0;
    localparam logic [1:0] KIND_SPEED  = 2'd1;
    localparam logic [1:0] KIND_PASS   = 2'd2;

    // request to the shared divider
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

endpackage

[src/cprr_ram.sv]
// ----------------------------------------------------------------------------
// cprr_ram: generic single-port-write RAM with registered read
// One write and one read address per cycle.
// ----------------------------------------------------------------------------
module cprr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/cprr_div.sv]
// ----------------------------------------------------------------------------
// cprr_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cprr_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cprr_pkg::div_req_t        req,
    output logic                      done,
    output logic [cprr_pkg::NUM_W-1:0] quo
);
    import cprr_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   shifted;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= req.num;
                den_reg  <= req.den;
            end
            else if (busy_reg)
            begin
                if (fits)
                begin
                    rem_reg <= DEN_W'(shifted - {1'b0, den_reg});
                end
                else
                begin
                    rem_reg <= shifted[DEN_W-1:0];
                end
                quo_reg <= {quo_reg[NUM_W-2:0], fits};
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

[src/cprr_sqrt.sv]
// ----------------------------------------------------------------------------
// cprr_sqrt: iterative square root, rounded to nearest
// Two radicand bits per cycle.
// ----------------------------------------------------------------------------
module cprr_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [32:0] root
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] src_reg;
    logic [31:0] root_reg;
    logic [34:0] rem_reg;

    logic [34:0] t;
    logic [34:0] trial;
    logic        fits;

    assign t     = {rem_reg[32:0], src_reg[63:62]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign fits  = t >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                src_reg  <= radicand;
                root_reg <= '0;
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                src_reg <= {src_reg[61:0], 2'b00};
                if (fits)
                begin
                    rem_reg  <= t - trial;
                    root_reg <= {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= t;
                    root_reg <= {root_reg[30:0], 1'b0};
                end
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    // round up when the remainder exceeds the root
    assign done = done_reg;
    assign root = {1'b0, root_reg} + 33'(rem_reg > {3'b0, root_reg});

endmodule

[src/contour_power_ramp_resampler.sv]
// ----------------------------------------------------------------------------
// contour_power_ramp_resampler: arc-length resampling with linear power ramp
// Walks the opening stretch of a contour and emits points with ramped powers.
// ----------------------------------------------------------------------------
// Usage:
//   Contour points enter on the s_ channel (x, y, speed; tuser = speed
//   present, tlast = last point of the contour). Results leave on the m_
//   channel (x, y, core, ring, speed; tuser = kind and overflow, tlast =
//   final result of the input point). Registers are written through cfg_we,
//   cfg_index, cfg_data while the block is idle; the user must keep to this,
//   as the block itself does not enforce it. One point is handled at a time;
//   s_tready is low from acceptance until all of its results have been taken.
//   Each loop pass computes the squares and the square root; each computed
//   step point adds four divisions (x, y, core, ring) on the shared divider.
//   Results are gathered in a 64-entry buffer and then drained one at a time,
//   the next being read only after the receiver has taken the current one;
//   the overflow flag is known only after the walk, which is why draining
//   waits for it.
//   Reset clears the registers and the walk state. A stalled receiver simply
//   holds the current result in the output register.
// ----------------------------------------------------------------------------
module contour_power_ramp_resampler (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // point_x, point_y, point_speed
    input  logic         s_tuser,   // speed_present
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // ramp_x, ramp_y, core_power, ring_power, ramp_speed
    output logic [2:0]   m_tuser,   // item_kind, overflow
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [19:0]  cfg_data
);
    import cprr_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DECIDE, S_LOOP, S_MX, S_MY, S_MS, S_CMP, S_SQRT,
        S_MDX, S_DVX, S_WDX, S_MDY, S_DVY, S_WDY,
        S_PC_MUL, S_PC_DIV, S_PC_WAIT, S_PR_MUL, S_PR_DIV, S_PR_WAIT,
        S_WRITE, S_FINISH, S_RD, S_LOAD, S_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_WAIT, PH_RAMP, PH_DONE
    } phase_t;

    state_t state_reg;
    phase_t phase_reg;

    // configuration
    logic [19:0] len_reg, step_reg;
    logic [15:0] core_s_reg, core_e_reg, ring_s_reg, ring_e_reg, start_idx_reg;

    // walk state
    logic signed [31:0] prev_x_reg, prev_y_reg;
    logic [TRAV_W-1:0]  trav_reg;
    logic [15:0]        cnt_reg;
    logic signed [31:0] first_speed_reg;

    // current input
    logic signed [31:0] px_reg, py_reg, spd_reg;
    logic               present_reg, last_reg;

    // loop datapath
    logic signed [32:0] dx_reg, dy_reg;
    logic [31:0]        axh_reg, ayh_reg;
    logic               big_reg, lt_reg, ent_loop_reg, sign_reg, ovf_reg;
    logic [63:0]        q_reg;
    logic [DEN_W-1:0]   dist_reg;
    logic [19:0]        arc_reg;
    logic [STEP_W-1:0]  steps_reg;
    logic signed [63:0] prod_reg;

    // pending result entry
    logic signed [31:0] ent_x_reg, ent_y_reg, ent_speed_reg;
    logic [15:0]        ent_core_reg, ent_ring_reg;
    logic [1:0]         ent_kind_reg;

    // buffer and output
    logic [BUF_CW-1:0]  n_reg, rd_ptr_reg;
    logic               m_valid_reg, m_last_reg;
    logic [127:0]       m_data_reg;
    logic [2:0]         m_user_reg;

    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_full;
    div_req_t           div_req;
    logic               div_done;
    logic [NUM_W-1:0]   div_quo;
    logic               sq_done;
    logic [32:0]        sq_root;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [63:0]        prod_mag;
    logic signed [16:0] core_diff, ring_diff;

    function automatic logic [15:0] sat_power(input logic [15:0] base, input logic neg,
                                              input logic [NUM_W-1:0] q);
        logic signed [41:0] sum;
        begin
            sum = $signed({26'b0, base}) + (neg ? -$signed({2'b0, q[39:0]})
                                                : $signed({2'b0, q[39:0]}));
            if (sum < 0)
                sat_power = 16'd0;
            else if (sum > 42'sd65535)
                sat_power = 16'hFFFF;
            else
                sat_power = sum[15:0];
        end
    endfunction

    function automatic logic signed [31:0] move(input logic signed [31:0] p,
                                                input logic neg, input logic [NUM_W-1:0] q);
        logic signed [33:0] d;
        begin
            d    = neg ? -$signed({1'b0, q[32:0]}) : $signed({1'b0, q[32:0]});
            move = p + d[31:0];
        end
    endfunction

    assign core_diff = $signed({1'b0, core_e_reg}) - $signed({1'b0, core_s_reg});
    assign ring_diff = $signed({1'b0, ring_e_reg}) - $signed({1'b0, ring_s_reg});

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MX:     begin mul_a = {2'b0, axh_reg}; mul_b = {2'b0, axh_reg}; end
            S_MY:     begin mul_a = {2'b0, ayh_reg}; mul_b = {2'b0, ayh_reg}; end
            S_MS:     begin mul_a = {14'b0, step_reg}; mul_b = {14'b0, step_reg}; end
            S_MDX:    begin mul_a = 34'(dx_reg); mul_b = {14'b0, arc_reg}; end
            S_MDY:    begin mul_a = 34'(dy_reg); mul_b = {14'b0, arc_reg}; end
            S_PC_MUL: begin mul_a = 34'(core_diff); mul_b = {12'b0, trav_reg}; end
            S_PR_MUL: begin mul_a = 34'(ring_diff); mul_b = {12'b0, trav_reg}; end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_full = mul_a * mul_b;
    assign prod_mag = prod_reg[63] ? 64'(-prod_reg) : 64'(prod_reg);

    // rounded division: (|n| + d/2) / d
    always_comb
    begin
        div_req.start = (state_reg == S_DVX) || (state_reg == S_DVY) ||
                        (state_reg == S_PC_DIV) || (state_reg == S_PR_DIV);
        if ((state_reg == S_PC_DIV) || (state_reg == S_PR_DIV))
            div_req.den = {13'b0, len_reg};
        else
            div_req.den = dist_reg;
        div_req.num = prod_mag[NUM_W-1:0] + NUM_W'(div_req.den >> 1);
    end

    cprr_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .done (div_done),
        .quo  (div_quo)
    );

    cprr_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (state_reg == S_CMP),
        .radicand(q_reg),
        .done    (sq_done),
        .root    (sq_root)
    );

    cprr_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(BUF_DEPTH)
    ) u_buf (
        .clk  (clk),
        .we   (state_reg == S_WRITE),
        .waddr(n_reg[BUF_AW-1:0]),
        .wdata({ent_kind_reg, ent_speed_reg, ent_ring_reg, ent_core_reg, ent_y_reg, ent_x_reg}),
        .raddr(rd_ptr_reg[BUF_AW-1:0]),
        .rdata(ram_rdata)
    );

    logic signed [32:0] dx_now, dy_now;
    logic [32:0]        ax_now, ay_now;
    logic               big_now;
    logic [DEN_W-1:0]   dist_now;
    logic [TRAV_W:0]    trav_plus_step;
    logic signed [31:0] spd_in;

    assign dx_now = $signed({px_reg[31], px_reg}) - $signed({prev_x_reg[31], prev_x_reg});
    assign dy_now = $signed({py_reg[31], py_reg}) - $signed({prev_y_reg[31], prev_y_reg});
    assign ax_now = dx_now[32] ? 33'(-dx_now) : 33'(dx_now);
    assign ay_now = dy_now[32] ? 33'(-dy_now) : 33'(dy_now);
    assign big_now = ax_now[32] | ax_now[31] | ay_now[32] | ay_now[31];
    assign dist_now = big_reg ? {sq_root[31:0], 1'b0} : sq_root;
    assign trav_plus_step = {1'b0, trav_reg} + {3'b0, step_reg};
    assign spd_in = s_tuser ? $signed(s_tdata[95:64]) : -32'sd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            phase_reg       <= PH_WAIT;
            len_reg         <= '0;
            step_reg        <= '0;
            core_s_reg      <= '0;
            core_e_reg      <= '0;
            ring_s_reg      <= '0;
            ring_e_reg      <= '0;
            start_idx_reg   <= '0;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            trav_reg        <= '0;
            cnt_reg         <= '0;
            first_speed_reg <= '0;
            n_reg           <= '0;
            rd_ptr_reg      <= '0;
            steps_reg       <= '0;
            ovf_reg         <= 1'b0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            prod_reg <= mul_full[63:0];

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_RAMP_LENGTH: len_reg       <= cfg_data;
                    REG_RAMP_STEP:   step_reg      <= cfg_data;
                    REG_CORE_START:  core_s_reg    <= cfg_data[15:0];
                    REG_CORE_END:    core_e_reg    <= cfg_data[15:0];
                    REG_RING_START:  ring_s_reg    <= cfg_data[15:0];
                    REG_RING_END:    ring_e_reg    <= cfg_data[15:0];
                    REG_START_INDEX: start_idx_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        px_reg      <= $signed(s_tdata[31:0]);
                        py_reg      <= $signed(s_tdata[63:32]);
                        spd_reg     <= spd_in;
                        present_reg <= s_tuser;
                        last_reg    <= s_tlast;
                        n_reg       <= '0;
                        steps_reg   <= '0;
                        ovf_reg     <= 1'b0;
                        state_reg   <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    if (cnt_reg == 16'd0)
                        first_speed_reg <= spd_reg;
                    ent_loop_reg <= 1'b0;
                    if (step_reg == 20'd0 || len_reg == 20'd0)
                    begin
                        ent_x_reg     <= px_reg;
                        ent_y_reg     <= py_reg;
                        ent_core_reg  <= '0;
                        ent_ring_reg  <= '0;
                        ent_speed_reg <= spd_reg;
                        ent_kind_reg  <= KIND_PASS;
                        state_reg     <= S_WRITE;
                    end
                    else if (phase_reg == PH_WAIT)
                    begin
                        if (cnt_reg == start_idx_reg)
                        begin
                            ent_x_reg     <= px_reg;
                            ent_y_reg     <= py_reg;
                            ent_core_reg  <= core_s_reg;
                            ent_ring_reg  <= ring_s_reg;
                            ent_speed_reg <= (cnt_reg == 16'd0) ? spd_reg : first_speed_reg;
                            ent_kind_reg  <= KIND_RAMP;
                            prev_x_reg    <= px_reg;
                            prev_y_reg    <= py_reg;
                            trav_reg      <= '0;
                            phase_reg     <= PH_RAMP;
                            state_reg     <= S_WRITE;
                        end
                        else
                            state_reg <= S_FINISH;
                    end
                    else if (phase_reg == PH_RAMP)
                        state_reg <= S_LOOP;
                    else
                        state_reg <= S_FINISH;
                end
                S_LOOP:
                begin
                    if (trav_reg >= TRAV_W'(len_reg))
                    begin
                        phase_reg <= PH_DONE;
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        dx_reg    <= dx_now;
                        dy_reg    <= dy_now;
                        big_reg   <= big_now;
                        axh_reg   <= big_now ? ax_now[32:1] : ax_now[31:0];
                        ayh_reg   <= big_now ? ay_now[32:1] : ay_now[31:0];
                        state_reg <= S_MX;
                    end
                end
                S_MX: state_reg <= S_MY;
                S_MY:
                begin
                    q_reg     <= 64'(prod_reg);
                    state_reg <= S_MS;
                end
                S_MS:
                begin
                    q_reg     <= q_reg + 64'(prod_reg);
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    lt_reg    <= !big_reg && (q_reg < 64'(prod_reg));
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (sq_done)
                    begin
                        dist_reg <= dist_now;
                        if (lt_reg)
                        begin
                            ent_loop_reg <= 1'b0;
                            if (q_reg > MIN_GAP_SQ)
                            begin
                                // short segment: the contour point itself
                                trav_reg      <= trav_reg + dist_now[TRAV_W-1:0];
                                if (trav_reg + dist_now[TRAV_W-1:0] >= TRAV_W'(len_reg))
                                    phase_reg <= PH_DONE;
                                prev_x_reg    <= px_reg;
                                prev_y_reg    <= py_reg;
                                ent_x_reg     <= px_reg;
                                ent_y_reg     <= py_reg;
                                ent_speed_reg <= spd_reg;
                                ent_kind_reg  <= KIND_RAMP;
                                state_reg     <= S_PC_MUL;
                            end
                            else if (present_reg)
                            begin
                                // near duplicate: velocity update only
                                ent_x_reg     <= prev_x_reg;
                                ent_y_reg     <= prev_y_reg;
                                ent_core_reg  <= '0;
                                ent_ring_reg  <= '0;
                                ent_speed_reg <= spd_reg;
                                ent_kind_reg  <= KIND_SPEED;
                                state_reg     <= S_WRITE;
                            end
                            else
                                state_reg <= S_FINISH;
                        end
                        else if (steps_reg == STEP_W'(MAX_STEPS))
                        begin
                            ovf_reg   <= 1'b1;
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            // step point; last one cut to land on the ramp length
                            if (trav_plus_step > {1'b0, TRAV_W'(len_reg)})
                            begin
                                arc_reg   <= 20'(TRAV_W'(len_reg) - trav_reg);
                                trav_reg  <= TRAV_W'(len_reg);
                                phase_reg <= PH_DONE;
                                ent_loop_reg <= 1'b0;
                            end
                            else
                            begin
                                arc_reg   <= step_reg;
                                trav_reg  <= trav_plus_step[TRAV_W-1:0];
                                ent_loop_reg <= 1'b1;
                            end
                            steps_reg     <= steps_reg + 1'b1;
                            ent_speed_reg <= -32'sd1;
                            ent_kind_reg  <= KIND_RAMP;
                            state_reg     <= S_MDX;
                        end
                    end
                end
                S_MDX: state_reg <= S_DVX;
                S_DVX:
                begin
                    sign_reg  <= prod_reg[63];
                    state_reg <= S_WDX;
                end
                S_WDX:
                begin
                    if (div_done)
                    begin
                        prev_x_reg <= move(prev_x_reg, sign_reg, div_quo);
                        ent_x_reg  <= move(prev_x_reg, sign_reg, div_quo);
                        state_reg  <= S_MDY;
                    end
                end
                S_MDY: state_reg <= S_DVY;
                S_DVY:
                begin
                    sign_reg  <= prod_reg[63];
                    state_reg <= S_WDY;
                end
                S_WDY:
                begin
                    if (div_done)
                    begin
                        prev_y_reg <= move(prev_y_reg, sign_reg, div_quo);
                        ent_y_reg  <= move(prev_y_reg, sign_reg, div_quo);
                        state_reg  <= S_PC_MUL;
                    end
                end
                S_PC_MUL: state_reg <= S_PC_DIV;
                S_PC_DIV:
                begin
                    sign_reg  <= prod_reg[63];
                    state_reg <= S_PC_WAIT;
                end
                S_PC_WAIT:
                begin
                    if (div_done)
                    begin
                        ent_core_reg <= sat_power(core_s_reg, sign_reg, div_quo);
                        state_reg    <= S_PR_MUL;
                    end
                end
                S_PR_MUL: state_reg <= S_PR_DIV;
                S_PR_DIV:
                begin
                    sign_reg  <= prod_reg[63];
                    state_reg <= S_PR_WAIT;
                end
                S_PR_WAIT:
                begin
                    if (div_done)
                    begin
                        ent_ring_reg <= sat_power(ring_s_reg, sign_reg, div_quo);
                        state_reg    <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    n_reg     <= n_reg + 1'b1;
                    state_reg <= ent_loop_reg ? S_LOOP : S_FINISH;
                end
                S_FINISH:
                begin
                    if (last_reg)
                    begin
                        prev_x_reg      <= '0;
                        prev_y_reg      <= '0;
                        trav_reg        <= '0;
                        cnt_reg         <= '0;
                        first_speed_reg <= '0;
                        phase_reg       <= PH_WAIT;
                    end
                    else if (cnt_reg != 16'hFFFF)
                        cnt_reg <= cnt_reg + 1'b1;
                    rd_ptr_reg <= '0;
                    state_reg  <= (n_reg == '0) ? S_IDLE : S_RD;
                end
                S_RD: state_reg <= S_LOAD;
                S_LOAD:
                begin
                    m_data_reg  <= ram_rdata[127:0];
                    m_user_reg  <= {ovf_reg, ram_rdata[129:128]};
                    m_last_reg  <= (rd_ptr_reg + 1'b1) == n_reg;
                    m_valid_reg <= 1'b1;
                    state_reg   <= S_OUT;
                end
                S_OUT:
                begin
                    if (m_tready)
                    begin
                        m_valid_reg <= 1'b0;
                        rd_ptr_reg  <= rd_ptr_reg + 1'b1;
                        state_reg   <= m_last_reg ? S_IDLE : S_RD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // input and output sides never overlap
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("input ready while a result is pending");

    a_buf: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= BUF_CW'(BUF_DEPTH))
        else $error("result buffer overrun");

    a_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE && ent_loop_reg) |-> (n_reg < BUF_CW'(MAX_STEPS)))
        else $error("step count exceeds limit");

endmodule

[sim/tb_contour_power_ramp_resampler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_contour_power_ramp_resampler: self-checking bench of the ramp resampler
// Streams contours with random gaps and receiver stalls, predicts every
// resampled point and its ramped powers, and compares each result transaction.
// ----------------------------------------------------------------------------
module tb_contour_power_ramp_resampler;
    import cprr_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int SETTLE_CYCLES  = 600;
    localparam int TARGET_POINTS  = 280;

    typedef enum int {WAIT_START, RAMPING, RAMP_DONE} walk_phase_t;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] core;
        logic [15:0] ring;
        logic [31:0] speed;
        logic [1:0]  kind;
        logic        ovf;
        logic        last;
    } ramp_point_t;

    class ramp_scoreboard;
        longint unsigned ramp_len, ramp_step, core_lo, core_hi, ring_lo, ring_hi, start_idx;
        longint      prev_x, prev_y, first_speed;
        longint unsigned travelled;
        int          point_count;
        walk_phase_t phase;
        ramp_point_t expected_points[$];
        int          errors;

        function new();
            errors = 0;
            ramp_len = 0; ramp_step = 0; core_lo = 0; core_hi = 0;
            ring_lo = 0; ring_hi = 0; start_idx = 0;
            clear_walk();
        endfunction

        function void clear_walk();
            prev_x = 0; prev_y = 0; travelled = 0; point_count = 0;
            first_speed = 0; phase = WAIT_START;
        endfunction

        function void set_reg(reg_idx_t idx, longint unsigned val);
            case (idx)
                REG_RAMP_LENGTH: ramp_len  = val & 20'hFFFFF;
                REG_RAMP_STEP:   ramp_step = val & 20'hFFFFF;
                REG_CORE_START:  core_lo   = val & 16'hFFFF;
                REG_CORE_END:    core_hi   = val & 16'hFFFF;
                REG_RING_START:  ring_lo   = val & 16'hFFFF;
                REG_RING_END:    ring_hi   = val & 16'hFFFF;
                REG_START_INDEX: start_idx = val & 16'hFFFF;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_points.size();
        endfunction

        function longint isqrt_near(longint unsigned q);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > q) b >>= 2;
            while (b != 0) begin
                if (q >= r + b) begin
                    q -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            if (q > r) r++;
            return longint'(r);
        endfunction

        // halves round away from zero
        function longint div_near(longint num, longint den);
            longint m, r;
            m = num < 0 ? -num : num;
            r = (m + den / 2) / den;
            return num < 0 ? -r : r;
        endfunction

        function logic [15:0] ramp_power(longint unsigned ps, longint unsigned pe);
            longint p;
            p = longint'(ps) + div_near((longint'(pe) - longint'(ps)) * longint'(travelled),
                                        longint'(ramp_len));
            if (p < 0) p = 0;
            if (p > 65535) p = 65535;
            return p[15:0];
        endfunction

        function ramp_point_t make_point(longint x, longint y, logic [15:0] core,
                                         logic [15:0] ring, longint spd, logic [1:0] kind);
            ramp_point_t r;
            r.x = x[31:0]; r.y = y[31:0]; r.core = core; r.ring = ring;
            r.speed = spd[31:0]; r.kind = kind; r.ovf = 1'b0; r.last = 1'b0;
            return r;
        endfunction

        function ramp_point_t ramped(longint x, longint y, longint spd);
            return make_point(x, y, ramp_power(core_lo, core_hi),
                              ramp_power(ring_lo, ring_hi), spd, KIND_RAMP);
        endfunction

        function void note_point(logic signed [31:0] px_in, logic signed [31:0] py_in,
                                 logic signed [31:0] spd_in, bit present, bit last);
            longint px, py, spd, dx, dy, seg_len;
            longint unsigned ax, ay, q, s, arc;
            bit big, cut, ovf;
            int steps;
            ramp_point_t batch[$];
            px = px_in; py = py_in;
            spd = present ? longint'(spd_in) : -1;
            ovf = 0;
            steps = 0;
            if (point_count == 0) first_speed = spd;
            if (ramp_step == 0 || ramp_len == 0) begin
                batch.insert(batch.size(), make_point(px, py, 16'd0, 16'd0, spd, KIND_PASS));
            end else if (phase == WAIT_START) begin
                if (point_count == start_idx) begin
                    batch.insert(batch.size(), make_point(px, py, core_lo[15:0], ring_lo[15:0],
                                                          first_speed, KIND_RAMP));
                    prev_x = px; prev_y = py; travelled = 0; phase = RAMPING;
                end
            end else if (phase == RAMPING) begin
                s = ramp_step;
                forever begin
                    if (travelled >= ramp_len) begin
                        phase = RAMP_DONE;
                        break;
                    end
                    dx = px - prev_x;
                    dy = py - prev_y;
                    ax = dx < 0 ? -dx : dx;
                    ay = dy < 0 ? -dy : dy;
                    big = ax >= 64'h8000_0000 || ay >= 64'h8000_0000;
                    if (big) begin
                        q = (ax >> 1) * (ax >> 1) + (ay >> 1) * (ay >> 1);
                        seg_len = 2 * isqrt_near(q);
                    end else begin
                        q = ax * ax + ay * ay;
                        seg_len = isqrt_near(q);
                    end
                    if (!big && q < s * s) begin
                        if (q > MIN_GAP_UM * MIN_GAP_UM) begin
                            travelled += seg_len;
                            batch.insert(batch.size(), ramped(px, py, spd));
                            prev_x = px; prev_y = py;
                        end else if (present) begin
                            batch.insert(batch.size(), make_point(prev_x, prev_y, 16'd0, 16'd0,
                                                                  spd, KIND_SPEED));
                        end
                        if (travelled >= ramp_len) phase = RAMP_DONE;
                        break;
                    end
                    if (steps >= MAX_STEPS) begin
                        ovf = 1;
                        break;
                    end
                    arc = s;
                    cut = travelled + s > ramp_len;
                    if (cut) arc = ramp_len - travelled;
                    prev_x += div_near(dx * longint'(arc), seg_len);
                    prev_y += div_near(dy * longint'(arc), seg_len);
                    travelled += arc;
                    batch.insert(batch.size(), ramped(prev_x, prev_y, -1));
                    steps++;
                    if (cut) begin
                        phase = RAMP_DONE;
                        break;
                    end
                end
            end
            if (point_count < 65535) point_count++;
            if (last) clear_walk();
            foreach (batch[i]) begin
                batch[i].ovf = ovf;
                batch[i].last = (i == batch.size() - 1);
                expected_points.insert(expected_points.size(), batch[i]);
            end
        endfunction

        function void compare(string name, longint unsigned exp, longint unsigned act);
            if (exp != act) begin
                $error("%s mismatch: expected %0h actual %0h", name, exp, act);
                errors++;
            end
        endfunction

        function void check_result(logic [127:0] data, logic [2:0] user, logic last);
            ramp_point_t e;
            if (expected_points.size() == 0) begin
                $error("unexpected result transaction: tdata %h", data);
                errors++;
                return;
            end
            e = expected_points.pop_front();
            compare("ramp_x", e.x, data[31:0]);
            compare("ramp_y", e.y, data[63:32]);
            compare("core_power", e.core, data[79:64]);
            compare("ring_power", e.ring, data[95:80]);
            compare("ramp_speed", e.speed, data[127:96]);
            compare("item_kind", e.kind, user[1:0]);
            compare("overflow", e.ovf, user[2]);
            compare("last_of_run", e.last, last);
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;   // point_x, point_y, point_speed
    logic         s_tuser;   // speed_present
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;   // ramp_x, ramp_y, core_power, ring_power, ramp_speed
    logic [2:0]   m_tuser;   // item_kind, overflow
    logic         m_tlast;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [19:0]  cfg_data;

    ramp_scoreboard sb;
    int  idle_cycles;
    int  points_sent;
    bit  tx_burst;
    bit  rx_burst;
    longint cur_x, cur_y;

    contour_power_ramp_resampler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[contour_power_ramp_resampler] ERROR");
            $finish;
        end
    end

    // result side: random stalls, checks each accepted transaction
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 40) == 0) rx_burst = ~rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                @(negedge clk) m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk) m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sb.check_result(m_tdata, m_tuser, m_tlast);
        end
    end

    task automatic write_reg(reg_idx_t idx, longint unsigned val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[19:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic set_config(longint unsigned len, longint unsigned step,
                              longint unsigned c0, longint unsigned c1,
                              longint unsigned r0, longint unsigned r1,
                              longint unsigned sidx);
        write_reg(REG_RAMP_LENGTH, len);
        write_reg(REG_RAMP_STEP, step);
        write_reg(REG_CORE_START, c0);
        write_reg(REG_CORE_END, c1);
        write_reg(REG_RING_START, r0);
        write_reg(REG_RING_END, r1);
        write_reg(REG_START_INDEX, sidx);
    endtask

    task automatic send_point(longint x, longint y, longint spd, bit present, bit last);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            @(negedge clk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {spd[31:0], y[31:0], x[31:0]};
        s_tuser  <= present;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        sb.note_point(x[31:0], y[31:0], spd[31:0], present, last);
        points_sent++;
    endtask

    // hold off the sender until the block has drained and settled
    task automatic drain_block();
        @(negedge clk) s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic longint rand_speed();
        case ($urandom_range(0, 3))
            0: return -1;
            1: return 64'h7FFF_FFFF;
            default: return longint'($urandom_range(0, 32'h7FFF_FFFF));
        endcase
    endfunction

    // random walk; mostly well-formed segments, some near duplicates and wild jumps
    task automatic send_contour(int npts, longint seg_max);
        longint x, y;
        int sel;
        for (int i = 0; i < npts; i++)
        begin
            sel = $urandom_range(0, 19);
            if (sel < 3)
            begin
                x = cur_x + $urandom_range(0, 2) - 1;
                y = cur_y;
            end else if (sel == 3)
            begin
                x = longint'(int'($urandom()));
                y = longint'(int'($urandom()));
            end else
            begin
                x = cur_x + longint'($urandom_range(0, 2 * seg_max)) - seg_max;
                y = cur_y + longint'($urandom_range(0, 2 * seg_max)) - seg_max;
            end
            cur_x = longint'(int'(x[31:0]));
            cur_y = longint'(int'(y[31:0]));
            send_point(cur_x, cur_y, rand_speed(), $urandom_range(0, 9) < 7, i == npts - 1);
        end
    endtask

    initial
    begin
        longint unsigned len, step;
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0; s_tlast = 1'b0;
        cfg_we = 1'b0; cfg_index = REG_RAMP_LENGTH; cfg_data = '0;
        idle_cycles = 0; points_sent = 0; tx_burst = 0; rx_burst = 0;
        repeat (6) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);

        // registers at reset: everything passes through
        send_point(-64'sd2147483648, 64'sd2147483647, -1, 1'b1, 1'b0);
        send_point(64'sd2147483647, -64'sd2147483648, 64'h7FFF_FFFF, 1'b0, 1'b0);
        send_point(0, 0, 0, 1'b1, 1'b1);
        drain_block();

        // basic ramp: two steps, a short point, near duplicates, cut at the end
        set_config(1000, 100, 0, 65535, 65535, 0, 0);
        send_point(0, 0, 1234, 1'b1, 1'b0);
        send_point(250, 0, 55, 1'b1, 1'b0);
        send_point(250, 1, 66, 1'b1, 1'b0);
        send_point(251, 1, 0, 1'b0, 1'b0);
        send_point(10000, 0, 77, 1'b1, 1'b0);
        send_point(20000, 5, 88, 1'b1, 1'b1);
        drain_block();

        // long ramp with unit step: step overflow and the large-segment path
        set_config(1000000, 1, 65535, 0, 0, 65535, 1);
        send_point(5, 5, 9, 1'b1, 1'b0);
        send_point(0, 0, 0, 1'b0, 1'b0);
        send_point(1000, 0, 3, 1'b1, 1'b0);
        send_point(-64'sd2147483648, 64'sd2147483647, -1, 1'b1, 1'b1);
        drain_block();

        // start index beyond the contour, then step equal to length
        set_config(1000000, 1000000, 100, 200, 300, 400, 65535);
        send_point(10, 10, 1, 1'b1, 1'b0);
        send_point(20, 20, 2, 1'b1, 1'b1);
        drain_block();
        write_reg(REG_START_INDEX, 0);
        send_point(0, 0, 5, 1'b1, 1'b0);
        send_point(700000, 0, 6, 1'b1, 1'b0);
        send_point(700000, 800000, 7, 1'b1, 1'b1);
        drain_block();

        // zero step disables, with nonzero length
        write_reg(REG_RAMP_STEP, 0);
        send_point(3, 4, 8, 1'b1, 1'b1);
        drain_block();

        while (points_sent < TARGET_POINTS)
        begin
            len = $urandom_range(1, 1000000);
            step = len / $urandom_range(1, 20);
            if (step == 0) step = 1;
            case ($urandom_range(0, 9))
                0: step = 0;
                1: len = 0;
                2: begin len = 1000000; step = $urandom_range(1, 1000000); end
                default: ;
            endcase
            if (step > 0 && len / step > 40) step = len / 40 + 1;
            set_config(len, step, $urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 15) == 0 ? 65535 : $urandom_range(0, 3));
            repeat ($urandom_range(2, 4))
            begin
                tx_burst = $urandom_range(0, 3) == 0;
                cur_x = longint'($urandom_range(0, 32'h7FFF_FFFF)) - 64'sd1073741824;
                cur_y = longint'($urandom_range(0, 32'h7FFF_FFFF)) - 64'sd1073741824;
                send_contour($urandom_range(3, 12), step == 0 ? 1000 : 3 * step);
            end
            drain_block();
        end

        if (sb.errors == 0)
            $display("[contour_power_ramp_resampler] OK");
        else
            $display("[contour_power_ramp_resampler] ERROR");
        $finish;
    end

endmodule
